// File: design/cbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbt_pkg: shared types and constants for the CAN bit timing calculator
// Widths of the arithmetic path, status and register codes, sequencer
// states and the sample point table.
// ----------------------------------------------------------------------------
package cbt_pkg;

  // arithmetic widths
  localparam int unsigned SPEED_W = 20;  // requested speed field
  localparam int unsigned RATE_W  = 23;  // bit rate in bit/s, up to 5e6
  localparam int unsigned NUM_W   = 26;  // oscillator in Hz, up to 63e6
  localparam int unsigned DEN_W   = 30;  // 2*(p+1)*rate for p up to 63
  localparam int unsigned PROD_W  = 2 * DEN_W;
  localparam int unsigned CNT_W   = $clog2(NUM_W);

  // scaling constants
  localparam int unsigned KBPS_LIMIT = 5000;
  localparam int unsigned KBPS_SCALE = 1000;
  localparam int unsigned HZ_PER_MHZ = 1000000;

  // legal bit length in quanta
  localparam int unsigned BT_MIN = 8;
  localparam int unsigned BT_MAX = 24;

  // configuration register indexes
  localparam logic CFG_OSC_MHZ = 1'b0;
  localparam logic CFG_SJW     = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_SEG_SHORT = 2'd2,
    ST_SJW_WIDE  = 2'd3
  } cbt_status_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_DIV_GO,
    S_DIV_WAIT,
    S_MUL_A,
    S_MUL_B,
    S_CMP,
    S_TAKE,
    S_NEXT,
    S_FINISH
  } cbt_state_t;

  // sample point floor(0.7*bt) for bt in 8..24
  function automatic logic [4:0] sample_point(input logic [4:0] bt);
    logic [4:0] sp;
    case (bt)
      5'd8:    sp = 5'd5;
      5'd9:    sp = 5'd6;
      5'd10:   sp = 5'd7;
      5'd11:   sp = 5'd7;
      5'd12:   sp = 5'd8;
      5'd13:   sp = 5'd9;
      5'd14:   sp = 5'd9;
      5'd15:   sp = 5'd10;
      5'd16:   sp = 5'd11;
      5'd17:   sp = 5'd11;
      5'd18:   sp = 5'd12;
      5'd19:   sp = 5'd13;
      5'd20:   sp = 5'd14;
      5'd21:   sp = 5'd14;
      5'd22:   sp = 5'd15;
      5'd23:   sp = 5'd16;
      5'd24:   sp = 5'd16;
      default: sp = 5'd0;
    endcase
    return sp;
  endfunction

endpackage

// File: design/cbt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbt_div: serial restoring divider
// Divides the oscillator frequency by the candidate divisor, one quotient
// bit per cycle, and pulses done with quotient and remainder held.
// ----------------------------------------------------------------------------
module cbt_div
  import cbt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient,
  output logic [DEN_W-1:0] remainder
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;

  logic [DEN_W:0]   rem_sh;
  logic             fits;
  logic [DEN_W:0]   rem_diff;

  // shift in the next dividend bit and trial subtract
  always_comb begin
    rem_sh   = {rem_r, quo_r[NUM_W-1]};
    fits     = (rem_sh >= {1'b0, divisor});
    rem_diff = rem_sh - {1'b0, divisor};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // quotient and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], fits};
      rem_r <= fits ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// File: design/can_bit_timing_calculator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_bit_timing_calculator: CAN bit timing register calculation
// Searches the prescalers for the bit length in quanta with the smallest
// fractional part inside 8..24, splits the bit at 70 percent and returns
// the three timing register bytes with a status code.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------
//   in      | input     | in_valid / in_ready   | in_bus_speed
//   out     | output    | out_valid / out_ready | out_cnf1_byte, out_cnf2_byte,
//           |           |                       | out_cnf3_byte, out_timing_status
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A request runs the serial divider once per prescaler, plus two shared
// multiplier passes for each in-range candidate after the first.
// Reset is synchronous, active low, and restores osc_mhz = 16, jump width 1.
// in_ready is high only while idle; a finished result sits in the output
// register and the next request is accepted while it waits to be taken.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module can_bit_timing_calculator
  import cbt_pkg::*;
#(
  parameter int PRESCALER_COUNT = 63
)
(
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SPEED_W-1:0] in_bus_speed,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_cnf1_byte,
  output logic [7:0]         out_cnf2_byte,
  output logic [7:0]         out_cnf3_byte,
  output logic [1:0]         out_timing_status,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [5:0]         cfg_data
);

  localparam int P_W = (PRESCALER_COUNT > 1) ? $clog2(PRESCALER_COUNT) : 1;

  cbt_state_t state_r, state_nxt;

  logic [5:0]        osc_mhz_r;
  logic [2:0]        sjw_cfg_r;
  logic [2:0]        sjw_r;
  logic [RATE_W-1:0] rate_r;
  logic [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]  den_r;
  logic [P_W-1:0]    p_r;
  logic              found_r;
  logic [DEN_W-1:0]  best_rem_r;
  logic [DEN_W-1:0]  best_den_r;
  logic [4:0]        best_bt_r;
  logic [5:0]        best_p_r;
  logic [PROD_W-1:0] prod_a_r;
  logic [PROD_W-1:0] prod_b_r;

  logic              out_valid_r;
  logic [7:0]        cnf1_r, cnf2_r, cnf3_r;
  cbt_status_t       status_r;

  logic              in_acc;
  logic              out_free;
  logic              div_start;
  logic              div_done;
  logic [NUM_W-1:0]  div_quo;
  logic [DEN_W-1:0]  div_rem;
  logic              in_range;
  logic              p_last;
  logic [DEN_W-1:0]  den_step;
  logic [DEN_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      osc_mhz_r <= 6'd16;
      sjw_cfg_r <= 3'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_OSC_MHZ: osc_mhz_r <= cfg_data;
        CFG_SJW:     sjw_cfg_r <= cfg_data[2:0];
      endcase
    end
  end

  // shared serial divider
  cbt_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (num_r),
    .divisor   (den_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign in_range = (div_quo >= NUM_W'(BT_MIN)) && (div_quo <= NUM_W'(BT_MAX));
  assign p_last   = (p_r == P_W'(PRESCALER_COUNT - 1));
  assign den_step = DEN_W'({rate_r, 1'b0});

  // shared multiplier for the cross-multiplied fraction compare
  always_comb begin
    mul_a = (state_r == S_MUL_A) ? div_rem    : best_rem_r;
    mul_b = (state_r == S_MUL_A) ? best_den_r : den_r;
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SETUP;
      end
      S_SETUP: begin
        state_nxt = (rate_r == '0) ? S_FINISH : S_DIV_GO;
      end
      S_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          if (!in_range)    state_nxt = S_NEXT;
          else if (found_r) state_nxt = S_MUL_A;
          else              state_nxt = S_TAKE;
        end
      end
      S_MUL_A: state_nxt = S_MUL_B;
      S_MUL_B: state_nxt = S_CMP;
      S_CMP: begin
        state_nxt = (prod_a_r < prod_b_r) ? S_TAKE : S_NEXT;
      end
      S_TAKE: state_nxt = S_NEXT;
      S_NEXT: begin
        state_nxt = p_last ? S_FINISH : S_DIV_GO;
      end
      S_FINISH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // search control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      p_r     <= '0;
    end else if (in_acc) begin
      found_r <= 1'b0;
      p_r     <= '0;
    end else if (state_r == S_TAKE) begin
      found_r <= 1'b1;
    end else if (state_r == S_NEXT && !p_last) begin
      p_r <= p_r + 1'b1;
    end
  end

  // request capture and search datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rate_r <= (in_bus_speed <= SPEED_W'(KBPS_LIMIT)) ?
                RATE_W'(in_bus_speed) * RATE_W'(KBPS_SCALE) : RATE_W'(in_bus_speed);
      num_r  <= NUM_W'(osc_mhz_r) * NUM_W'(HZ_PER_MHZ);
      if (sjw_cfg_r == 3'd0)     sjw_r <= 3'd1;
      else if (sjw_cfg_r > 3'd4) sjw_r <= 3'd4;
      else                       sjw_r <= sjw_cfg_r;
    end
    if (state_r == S_SETUP) den_r <= den_step;
    if (state_r == S_NEXT && !p_last) den_r <= den_r + den_step;
    if (state_r == S_MUL_A) prod_a_r <= mul_p;
    if (state_r == S_MUL_B) prod_b_r <= mul_p;
    if (state_r == S_TAKE) begin
      best_rem_r <= div_rem;
      best_den_r <= den_r;
      best_bt_r  <= div_quo[4:0];
      best_p_r   <= 6'(p_r);
    end
  end

  // segment split and register bytes
  logic [4:0]  sp, prop, ph1, ph2, prop_m1, ph1_m1, ph2_m1;
  logic [1:0]  sjw_m1;
  cbt_status_t status_nxt;

  always_comb begin
    sp      = sample_point(best_bt_r);
    prop    = (sp - 5'd1) >> 1;
    ph1     = sp - prop - 5'd1;
    ph2     = best_bt_r - sp;
    prop_m1 = prop - 5'd1;
    ph1_m1  = ph1 - 5'd1;
    ph2_m1  = ph2 - 5'd1;
    sjw_m1  = 2'(sjw_r - 3'd1);
    if (!found_r)                      status_nxt = ST_NO_FIT;
    else if ((prop + ph1) < ph2)       status_nxt = ST_SEG_SHORT;
    else if (ph2 <= {2'b00, sjw_r})    status_nxt = ST_SJW_WIDE;
    else                               status_nxt = ST_OK;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FINISH && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FINISH && out_free) begin
      status_r <= status_nxt;
      if (status_nxt == ST_OK) begin
        cnf1_r <= {sjw_m1, best_p_r};
        cnf2_r <= {1'b1, 1'b0, ph1_m1[2:0], prop_m1[2:0]};
        cnf3_r <= {1'b1, 2'b00, ph2_m1};
      end else begin
        cnf1_r <= 8'h00;
        cnf2_r <= 8'h00;
        cnf3_r <= 8'h00;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cnf1_byte     = cnf1_r;
  assign out_cnf2_byte     = cnf2_r;
  assign out_cnf3_byte     = cnf3_r;
  assign out_timing_status = status_r;

  // divider finishes only while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV_WAIT)
    else $error("divider done outside wait state");

  // a kept candidate always has a legal bit length
  a_best_bt_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (found_r && state_r == S_FINISH) |->
      (best_bt_r >= 5'(BT_MIN) && best_bt_r <= 5'(BT_MAX)))
    else $error("kept bit length out of range");

  // prescaler counter never runs past the last prescaler
  a_p_bound: assert property (@(posedge clk) disable iff (!rst_n)
    p_r <= P_W'(PRESCALER_COUNT - 1))
    else $error("prescaler counter overrun");

  // failed results carry zero register bytes
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != ST_OK) |->
      (cnf1_r == 8'h00 && cnf2_r == 8'h00 && cnf3_r == 8'h00))
    else $error("nonzero bytes on failed result");

  // good results have the fixed top bits of cnf2 and cnf3 set
  a_ok_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_OK) |-> (cnf2_r[7] && cnf3_r[7]))
    else $error("good result missing top bits");

endmodule
